[hw/rtl/sfsm_pkg.sv]
// Shared constants, micro-op codes and control structs for the SPI flash slave model.
package sfsm_pkg;

   localparam int MEM_WORDS_DEF    = 65536;
   localparam int SECTOR_WORDS_DEF = 1024;

   // SPI opcodes
   localparam logic [7:0] OPC_READ_STATUS = 8'h05;
   localparam logic [7:0] OPC_WRITE_EN    = 8'h06;
   localparam logic [7:0] OPC_WRITE_DIS   = 8'h04;
   localparam logic [7:0] OPC_JEDEC_ID    = 8'h9F;
   localparam logic [7:0] OPC_FAST_READ   = 8'h0B;
   localparam logic [7:0] OPC_PAGE_PROG   = 8'h02;
   localparam logic [7:0] OPC_SECT_ERASE  = 8'h20;

   localparam logic [7:0]  JEDEC_MFR   = 8'hAA;
   localparam logic [7:0]  STATUS_WEL  = 8'h02;
   localparam logic [7:0]  IDLE_BYTE   = 8'hFF;
   localparam logic [31:0] ERASED_WORD = 32'hFFFF_FFFF;

   // transaction phases
   localparam logic [3:0] PH_IDLE     = 4'd0;
   localparam logic [3:0] PH_HOLD     = 4'd1;
   localparam logic [3:0] PH_STATUS   = 4'd2;
   localparam logic [3:0] PH_ID0      = 4'd3;
   localparam logic [3:0] PH_ID1      = 4'd4;
   localparam logic [3:0] PH_ID2      = 4'd5;
   localparam logic [3:0] PH_ADDR_HI  = 4'd6;
   localparam logic [3:0] PH_ADDR_MID = 4'd7;
   localparam logic [3:0] PH_ADDR_LO  = 4'd8;
   localparam logic [3:0] PH_DUMMY    = 4'd9;
   localparam logic [3:0] PH_READ     = 4'd10;
   localparam logic [3:0] PH_PROG     = 4'd11;

   // error codes
   localparam logic [2:0] ERR_OK         = 3'd0;
   localparam logic [2:0] ERR_MISALIGNED = 3'd1;
   localparam logic [2:0] ERR_RANGE      = 3'd2;
   localparam logic [2:0] ERR_NOT_ERASED = 3'd3;
   localparam logic [2:0] ERR_PAGE_OVF   = 3'd4;

   // micro-ops driving the datapath
   localparam logic [3:0] U_NOP      = 4'd0;
   localparam logic [3:0] U_ABORT    = 4'd1;
   localparam logic [3:0] U_CMD      = 4'd2;
   localparam logic [3:0] U_STATUS   = 4'd3;
   localparam logic [3:0] U_ID       = 4'd4;
   localparam logic [3:0] U_ADDR_HI  = 4'd5;
   localparam logic [3:0] U_ADDR_MID = 4'd6;
   localparam logic [3:0] U_ADDR_LO  = 4'd7;
   localparam logic [3:0] U_ERASE    = 4'd8;
   localparam logic [3:0] U_DUMMY    = 4'd9;
   localparam logic [3:0] U_READ     = 4'd10;
   localparam logic [3:0] U_PROGRAM  = 4'd11;
   localparam logic [3:0] U_CLEAR    = 4'd12;
   localparam logic [3:0] U_FIN      = 4'd13;

   // sequencer branch conditions
   localparam logic [2:0] C_NEXT      = 3'd0;
   localparam logic [2:0] C_GOTO      = 3'd1;
   localparam logic [2:0] C_WAIT_IN   = 3'd2;
   localparam logic [2:0] C_DISPATCH  = 3'd3;
   localparam logic [2:0] C_IF_ERASE  = 3'd4;
   localparam logic [2:0] C_LOOP_SECT = 3'd5;
   localparam logic [2:0] C_LOOP_MEM  = 3'd6;
   localparam logic [2:0] C_WAIT_OUT  = 3'd7;

   typedef struct packed {
      logic [3:0] uop;
      logic [2:0] cond;
      logic [4:0] target;
   } uword_type;

   // sequencer -> datapath
   typedef struct packed {
      logic       fetch;
      logic [3:0] uop;
   } ctrl_type;

   // datapath -> sequencer
   typedef struct packed {
      logic       accept;
      logic       desel;
      logic [3:0] phase;
      logic       erase_go;
      logic       sect_last;
      logic       mem_last;
      logic       out_free;
   } stat_type;

endpackage

[hw/rtl/sfsm_mem.sv]
// Word store of the flash array: one write port, one registered read port.
module sfsm_mem #(
   parameter int MEM_WORDS = sfsm_pkg::MEM_WORDS_DEF
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(MEM_WORDS)-1:0] wr_addr,
   input  logic [31:0]                  wr_data,
   input  logic [$clog2(MEM_WORDS)-1:0] rd_addr,
   output logic [31:0]                  rd_data
);

   logic [31:0] mem_ff [MEM_WORDS];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/sfsm_seq.sv]
// Microcode sequencer: step counter, control store and branch logic.
module sfsm_seq (
   input  logic               clock,
   input  logic               reset,
   input  sfsm_pkg::stat_type stat,
   output sfsm_pkg::ctrl_type ctrl
);

   // control store addresses
   localparam logic [4:0] ST_FETCH    = 5'd0;
   localparam logic [4:0] ST_DISP     = 5'd1;
   localparam logic [4:0] ST_ABORT    = 5'd2;
   localparam logic [4:0] ST_CMD      = 5'd3;
   localparam logic [4:0] ST_HOLD     = 5'd4;
   localparam logic [4:0] ST_STATUS   = 5'd5;
   localparam logic [4:0] ST_ID       = 5'd6;
   localparam logic [4:0] ST_ADDR_HI  = 5'd7;
   localparam logic [4:0] ST_ADDR_MID = 5'd8;
   localparam logic [4:0] ST_ADDR_LO  = 5'd9;
   localparam logic [4:0] ST_FIN      = 5'd10;
   localparam logic [4:0] ST_ERASE    = 5'd11;
   localparam logic [4:0] ST_DUMMY    = 5'd12;
   localparam logic [4:0] ST_RD_ISSUE = 5'd13;
   localparam logic [4:0] ST_RD_DATA  = 5'd14;
   localparam logic [4:0] ST_PG_ISSUE = 5'd15;
   localparam logic [4:0] ST_PG_DATA  = 5'd16;
   localparam logic [4:0] ST_CLEAR    = 5'd17;

   function automatic sfsm_pkg::uword_type rom(input logic [4:0] s);
      sfsm_pkg::uword_type w;
      unique case (s)
         ST_FETCH:    w = '{sfsm_pkg::U_NOP,      sfsm_pkg::C_WAIT_IN,   ST_DISP};
         ST_DISP:     w = '{sfsm_pkg::U_NOP,      sfsm_pkg::C_DISPATCH,  ST_FETCH};
         ST_ABORT:    w = '{sfsm_pkg::U_ABORT,    sfsm_pkg::C_GOTO,      ST_FIN};
         ST_CMD:      w = '{sfsm_pkg::U_CMD,      sfsm_pkg::C_GOTO,      ST_FIN};
         ST_HOLD:     w = '{sfsm_pkg::U_NOP,      sfsm_pkg::C_GOTO,      ST_FIN};
         ST_STATUS:   w = '{sfsm_pkg::U_STATUS,   sfsm_pkg::C_GOTO,      ST_FIN};
         ST_ID:       w = '{sfsm_pkg::U_ID,       sfsm_pkg::C_GOTO,      ST_FIN};
         ST_ADDR_HI:  w = '{sfsm_pkg::U_ADDR_HI,  sfsm_pkg::C_GOTO,      ST_FIN};
         ST_ADDR_MID: w = '{sfsm_pkg::U_ADDR_MID, sfsm_pkg::C_GOTO,      ST_FIN};
         ST_ADDR_LO:  w = '{sfsm_pkg::U_ADDR_LO,  sfsm_pkg::C_IF_ERASE,  ST_ERASE};
         ST_FIN:      w = '{sfsm_pkg::U_FIN,      sfsm_pkg::C_WAIT_OUT,  ST_FETCH};
         ST_ERASE:    w = '{sfsm_pkg::U_ERASE,    sfsm_pkg::C_LOOP_SECT, ST_FIN};
         ST_DUMMY:    w = '{sfsm_pkg::U_DUMMY,    sfsm_pkg::C_GOTO,      ST_FIN};
         ST_RD_ISSUE: w = '{sfsm_pkg::U_NOP,      sfsm_pkg::C_NEXT,      ST_FETCH};
         ST_RD_DATA:  w = '{sfsm_pkg::U_READ,     sfsm_pkg::C_GOTO,      ST_FIN};
         ST_PG_ISSUE: w = '{sfsm_pkg::U_NOP,      sfsm_pkg::C_NEXT,      ST_FETCH};
         ST_PG_DATA:  w = '{sfsm_pkg::U_PROGRAM,  sfsm_pkg::C_GOTO,      ST_FIN};
         ST_CLEAR:    w = '{sfsm_pkg::U_CLEAR,    sfsm_pkg::C_LOOP_MEM,  ST_FETCH};
         default:     w = '{sfsm_pkg::U_NOP,      sfsm_pkg::C_GOTO,      ST_FETCH};
      endcase
      return w;
   endfunction

   logic [4:0]          step_ff, step_in;
   logic [4:0]          step_inc;
   logic [4:0]          entry;
   sfsm_pkg::uword_type word;

   assign word     = rom(step_ff);
   assign step_inc = step_ff + 5'd1;

   // dispatch on the phase left by the previous beat, or abort on a deselect
   always_comb begin
      if (stat.desel) begin
         entry = ST_ABORT;
      end else begin
         unique case (stat.phase)
            sfsm_pkg::PH_IDLE:     entry = ST_CMD;
            sfsm_pkg::PH_HOLD:     entry = ST_HOLD;
            sfsm_pkg::PH_STATUS:   entry = ST_STATUS;
            sfsm_pkg::PH_ID0:      entry = ST_ID;
            sfsm_pkg::PH_ID1:      entry = ST_ID;
            sfsm_pkg::PH_ID2:      entry = ST_ID;
            sfsm_pkg::PH_ADDR_HI:  entry = ST_ADDR_HI;
            sfsm_pkg::PH_ADDR_MID: entry = ST_ADDR_MID;
            sfsm_pkg::PH_ADDR_LO:  entry = ST_ADDR_LO;
            sfsm_pkg::PH_DUMMY:    entry = ST_DUMMY;
            sfsm_pkg::PH_READ:     entry = ST_RD_ISSUE;
            sfsm_pkg::PH_PROG:     entry = ST_PG_ISSUE;
            default:               entry = ST_ABORT;
         endcase
      end
   end

   always_comb begin
      unique case (word.cond)
         sfsm_pkg::C_NEXT:      step_in = step_inc;
         sfsm_pkg::C_GOTO:      step_in = word.target;
         sfsm_pkg::C_WAIT_IN:   step_in = stat.accept    ? word.target : step_ff;
         sfsm_pkg::C_DISPATCH:  step_in = entry;
         sfsm_pkg::C_IF_ERASE:  step_in = stat.erase_go  ? word.target : step_inc;
         sfsm_pkg::C_LOOP_SECT: step_in = stat.sect_last ? word.target : step_ff;
         sfsm_pkg::C_LOOP_MEM:  step_in = stat.mem_last  ? word.target : step_ff;
         sfsm_pkg::C_WAIT_OUT:  step_in = stat.out_free  ? word.target : step_ff;
         default:               step_in = ST_FETCH;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_CLEAR;
      end else begin
         step_ff <= step_in;
      end
   end

   assign ctrl.fetch = (step_ff == ST_FETCH);
   assign ctrl.uop   = word.uop;

endmodule

[hw/rtl/sfsm_dp.sv]
// Datapath: transaction registers, beat capture, memory access and result register.
module sfsm_dp #(
   parameter int MEM_WORDS    = sfsm_pkg::MEM_WORDS_DEF,
   parameter int SECTOR_WORDS = sfsm_pkg::SECTOR_WORDS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  sfsm_pkg::ctrl_type           ctrl,
   output sfsm_pkg::stat_type           stat,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic                         in_desel,
   input  logic                         in_eoc,
   input  logic [7:0]                   in_byte,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [7:0]                   out_byte,
   output logic                         out_err_valid,
   output logic [2:0]                   out_err_code,
   output logic                         mem_wr_en,
   output logic [$clog2(MEM_WORDS)-1:0] mem_wr_addr,
   output logic [31:0]                  mem_wr_data,
   output logic [$clog2(MEM_WORDS)-1:0] mem_rd_addr,
   input  logic [31:0]                  mem_rd_data
);

   localparam int          AW        = $clog2(MEM_WORDS);
   localparam logic [24:0] MEM_BYTES = 25'(MEM_WORDS * 4);
   localparam logic [25:0] MEM_LIM   = 26'(MEM_WORDS);
   localparam logic [25:0] SECT_LEN  = 26'(SECTOR_WORDS);
   localparam logic [AW-1:0] SECT_LAST = AW'(SECTOR_WORDS - 1);
   localparam logic [AW-1:0] MEM_LAST  = AW'(MEM_WORDS - 1);
   localparam logic [7:0]  ID_HI     = 8'((MEM_WORDS >> 18) & 255);
   localparam logic [7:0]  ID_LO     = 8'((MEM_WORDS >> 10) & 255);

   function automatic logic [23:0] next_addr(input logic [23:0] a);
      logic [24:0] inc;
      inc = {1'b0, a} + 25'd1;
      return (inc >= MEM_BYTES) ? 24'd0 : inc[23:0];
   endfunction

   // transaction state
   logic [3:0]    phase_ff, phase_in;
   logic [7:0]    opcode_ff, opcode_in;
   logic          wen_ff, wen_in;
   logic [23:0]   addr_ff, addr_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   // captured beat
   logic          desel_ff, eoc_ff;
   logic [7:0]    byte_ff;
   // result being built
   logic [7:0]    rx_ff, rx_in;
   logic          ev_ff, ev_in;
   logic [2:0]    ec_ff, ec_in;
   // output register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_byte_ff;
   logic          rsp_ev_ff;
   logic [2:0]    rsp_ec_ff;

   logic          accept, out_free;
   logic [23:0]   addr_lo;
   logic          lo_in_range, lo_aligned, lo_fits;
   logic [25:0]   sect_end;
   logic [4:0]    lane_sh;
   logic [7:0]    lane;
   logic [7:0]    merged;
   logic [23:0]   addr_next;
   logic [AW-1:0] word_idx;

   assign accept   = in_valid && ctrl.fetch;
   assign in_ready = ctrl.fetch;
   assign out_free = !rsp_valid_ff || out_ready;

   assign addr_lo     = {addr_ff[23:8], byte_ff};
   assign lo_in_range = {1'b0, addr_lo} < MEM_BYTES;
   assign lo_aligned  = (addr_lo[1:0] == 2'd0);
   assign sect_end    = 26'(addr_lo[23:2]) + SECT_LEN;
   assign lo_fits     = !(sect_end > MEM_LIM);

   assign word_idx  = addr_ff[AW+1:2];
   assign lane_sh   = {addr_ff[1:0], 3'b000};
   assign lane      = 8'(mem_rd_data >> lane_sh);
   assign merged    = lane & byte_ff;
   assign addr_next = next_addr(addr_ff);

   assign stat.accept    = accept;
   assign stat.desel     = desel_ff;
   assign stat.phase     = phase_ff;
   assign stat.erase_go  = lo_in_range && (opcode_ff == sfsm_pkg::OPC_SECT_ERASE) && wen_ff
                           && lo_aligned && lo_fits;
   assign stat.sect_last = (cnt_ff == SECT_LAST);
   assign stat.mem_last  = (cnt_ff == MEM_LAST);
   assign stat.out_free  = out_free;

   assign mem_rd_addr = word_idx;

   always_comb begin
      phase_in     = phase_ff;
      opcode_in    = opcode_ff;
      wen_in       = wen_ff;
      addr_in      = addr_ff;
      cnt_in       = cnt_ff;
      rx_in        = rx_ff;
      ev_in        = ev_ff;
      ec_in        = ec_ff;
      rsp_valid_in = rsp_valid_ff && !out_ready;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = word_idx;
      mem_wr_data  = sfsm_pkg::ERASED_WORD;

      if (accept) begin
         rx_in = sfsm_pkg::IDLE_BYTE;
         ev_in = 1'b0;
         ec_in = sfsm_pkg::ERR_OK;
      end

      unique case (ctrl.uop)
         sfsm_pkg::U_ABORT: phase_in = sfsm_pkg::PH_IDLE;
         sfsm_pkg::U_CMD: begin
            opcode_in = byte_ff;
            unique case (byte_ff)
               sfsm_pkg::OPC_READ_STATUS: phase_in = sfsm_pkg::PH_STATUS;
               sfsm_pkg::OPC_FAST_READ,
               sfsm_pkg::OPC_PAGE_PROG,
               sfsm_pkg::OPC_SECT_ERASE:  phase_in = sfsm_pkg::PH_ADDR_HI;
               sfsm_pkg::OPC_WRITE_EN: begin
                  phase_in = sfsm_pkg::PH_HOLD;
                  wen_in   = 1'b1;
               end
               sfsm_pkg::OPC_WRITE_DIS: begin
                  phase_in = sfsm_pkg::PH_HOLD;
                  wen_in   = 1'b0;
               end
               sfsm_pkg::OPC_JEDEC_ID:    phase_in = sfsm_pkg::PH_ID0;
               default: ;
            endcase
         end
         sfsm_pkg::U_STATUS: begin
            rx_in    = wen_ff ? sfsm_pkg::STATUS_WEL : 8'h00;
            phase_in = sfsm_pkg::PH_HOLD;
         end
         sfsm_pkg::U_ID: begin
            priority if (phase_ff == sfsm_pkg::PH_ID0) begin
               rx_in    = sfsm_pkg::JEDEC_MFR;
               phase_in = sfsm_pkg::PH_ID1;
            end else if (phase_ff == sfsm_pkg::PH_ID1) begin
               rx_in    = ID_HI;
               phase_in = sfsm_pkg::PH_ID2;
            end else begin
               rx_in    = ID_LO;
               phase_in = sfsm_pkg::PH_HOLD;
            end
         end
         sfsm_pkg::U_ADDR_HI: begin
            addr_in  = {byte_ff, 16'h0000};
            phase_in = sfsm_pkg::PH_ADDR_MID;
         end
         sfsm_pkg::U_ADDR_MID: begin
            addr_in  = {addr_ff[23:16], byte_ff, 8'h00};
            phase_in = sfsm_pkg::PH_ADDR_LO;
         end
         sfsm_pkg::U_ADDR_LO: begin
            addr_in = addr_lo;
            cnt_in  = '0;
            if (!lo_in_range) begin
               phase_in = sfsm_pkg::PH_HOLD;
            end else begin
               priority case (opcode_ff)
                  sfsm_pkg::OPC_SECT_ERASE: begin
                     if (wen_ff) begin
                        ev_in = 1'b1;
                        priority if (!lo_aligned) ec_in = sfsm_pkg::ERR_MISALIGNED;
                        else if (!lo_fits)        ec_in = sfsm_pkg::ERR_RANGE;
                        else                      ec_in = sfsm_pkg::ERR_OK;
                     end
                     wen_in   = 1'b0;
                     phase_in = sfsm_pkg::PH_HOLD;
                  end
                  sfsm_pkg::OPC_FAST_READ: phase_in = sfsm_pkg::PH_DUMMY;
                  sfsm_pkg::OPC_PAGE_PROG: phase_in = sfsm_pkg::PH_PROG;
                  default:                 phase_in = sfsm_pkg::PH_IDLE;
               endcase
            end
         end
         sfsm_pkg::U_ERASE: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = word_idx + cnt_ff;
            cnt_in      = stat.sect_last ? '0 : cnt_ff + AW'(1);
         end
         sfsm_pkg::U_DUMMY: phase_in = sfsm_pkg::PH_READ;
         sfsm_pkg::U_READ: begin
            rx_in   = lane;
            addr_in = addr_next;
         end
         sfsm_pkg::U_PROGRAM: begin
            if ((~(lane | byte_ff)) != 8'h00) begin
               ev_in    = 1'b1;
               ec_in    = sfsm_pkg::ERR_NOT_ERASED;
               phase_in = sfsm_pkg::PH_IDLE;
            end else begin
               mem_wr_en   = 1'b1;
               mem_wr_data = (mem_rd_data & ~(32'h0000_00FF << lane_sh))
                             | (32'(merged) << lane_sh);
               addr_in     = addr_next;
               if (addr_next[7:0] == 8'h00 && !eoc_ff) begin
                  ev_in    = 1'b1;
                  ec_in    = sfsm_pkg::ERR_PAGE_OVF;
                  phase_in = sfsm_pkg::PH_IDLE;
               end
            end
         end
         sfsm_pkg::U_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = cnt_ff;
            cnt_in      = stat.mem_last ? '0 : cnt_ff + AW'(1);
         end
         sfsm_pkg::U_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (!desel_ff && eoc_ff) begin
                  phase_in = sfsm_pkg::PH_IDLE;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= sfsm_pkg::PH_IDLE;
         opcode_ff    <= 8'h00;
         wen_ff       <= 1'b0;
         addr_ff      <= 24'h000000;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         opcode_ff    <= opcode_in;
         wen_ff       <= wen_in;
         addr_ff      <= addr_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         desel_ff <= in_desel;
         eoc_ff   <= in_eoc;
         byte_ff  <= in_byte;
      end
      rx_ff <= rx_in;
      ev_ff <= ev_in;
      ec_ff <= ec_in;
      if (ctrl.uop == sfsm_pkg::U_FIN && out_free) begin
         rsp_byte_ff <= rx_ff;
         rsp_ev_ff   <= ev_ff;
         rsp_ec_ff   <= ec_ff;
      end
   end

   assign out_valid     = rsp_valid_ff;
   assign out_byte      = rsp_byte_ff;
   assign out_err_valid = rsp_ev_ff;
   assign out_err_code  = rsp_ec_ff;

endmodule

[hw/rtl/spi_flash_slave_model.sv]
// Top level of the SPI flash slave model: sequencer, datapath and flash word store.
//
// Each request beat is one SPI byte transfer (tdata = host byte, tlast = chip
// select rises after it, tuser = chip select was inactive before it); each
// response beat carries the byte shifted back plus the error report. A small
// microcode program steps through every beat: fetch, dispatch on the current
// transaction phase, one datapath step, and a finish step that loads the
// response register. Reads and programme beats add an issue step before the
// datapath step for the registered memory read. The closing address byte of a
// permitted sector erase adds a loop over its SECTOR_WORDS words, one word
// written per cycle through the single memory write port, which sets the
// worst case. A new beat is taken while the previous response still waits
// in the output register; the finish step only stalls when that register
// is still full. After reset the block sweeps the whole store to the erased
// value, one word per cycle, and req_tready stays low until the sweep ends.
module spi_flash_slave_model #(
   parameter int MEM_WORDS    = sfsm_pkg::MEM_WORDS_DEF,
   parameter int SECTOR_WORDS = sfsm_pkg::SECTOR_WORDS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,  // [7:0] tx_byte
   input  logic       req_tlast,  // end_of_command
   input  logic [0:0] req_tuser,  // [0] deselect_before
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,  // [7:0] rx_byte
   output logic [3:0] rsp_tuser   // [0] error_valid, [3:1] error_code
);

   localparam int AW = $clog2(MEM_WORDS);

   sfsm_pkg::ctrl_type ctrl;
   sfsm_pkg::stat_type stat;

   logic          mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   logic [31:0]   mem_wr_data;
   logic [AW-1:0] mem_rd_addr;
   logic [31:0]   mem_rd_data;
   logic          err_valid;
   logic [2:0]    err_code;

   sfsm_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   sfsm_dp #(
      .MEM_WORDS    (MEM_WORDS),
      .SECTOR_WORDS (SECTOR_WORDS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .stat          (stat),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .in_desel      (req_tuser[0]),
      .in_eoc        (req_tlast),
      .in_byte       (req_tdata),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_byte      (rsp_tdata),
      .out_err_valid (err_valid),
      .out_err_code  (err_code),
      .mem_wr_en     (mem_wr_en),
      .mem_wr_addr   (mem_wr_addr),
      .mem_wr_data   (mem_wr_data),
      .mem_rd_addr   (mem_rd_addr),
      .mem_rd_data   (mem_rd_data)
   );

   sfsm_mem #(
      .MEM_WORDS (MEM_WORDS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // error report rides in tuser, valid flag lowest
   assign rsp_tuser = {err_code, err_valid};

endmodule

[tb/flash_reply_check.sv]
// Response checker for the SPI flash slave model: predicts every response beat and compares it.
module flash_reply_check #(
   parameter int MEM_WORDS    = sfsm_pkg::MEM_WORDS_DEF,
   parameter int SECTOR_WORDS = sfsm_pkg::SECTOR_WORDS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic [7:0]        req_tdata,  // [7:0] tx_byte
   input  logic              req_tlast,  // end_of_command
   input  logic [0:0]        req_tuser,  // [0] deselect_before
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [7:0]        rsp_tdata,  // [7:0] rx_byte
   input  logic [3:0]        rsp_tuser,  // [0] error_valid, [3:1] error_code
   output int unsigned       fail_count,
   output int unsigned       pending
);
   import sfsm_pkg::*;

   localparam int unsigned MEM_BYTES = MEM_WORDS * 4;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       err_valid;
      logic [2:0] err_code;
   } reply_t;

   // mirror of the flash state
   logic [3:0]  ph;
   logic [7:0]  opcode;
   logic        wel;
   logic [23:0] addr;
   logic [31:0] flash_mem [MEM_WORDS];

   reply_t awaited_replies [$];
   reply_t want;

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned exp_val);
      fail_count++;
      if (fail_count <= 40)
         $display("%0t: %s: got %0h, expected %0h", $time, what, got, exp_val);
   endtask

   // read and programme addresses wrap at the end of the store
   function automatic logic [23:0] advance_addr(input logic [23:0] a);
      logic [23:0] n;
      n = a + 24'd1;
      if (32'(n) >= MEM_BYTES) n = '0;
      return n;
   endfunction

   // one SPI byte transfer against the mirrored state
   function automatic reply_t flash_transfer(input logic desel, input logic eoc,
                                             input logic [7:0] b);
      reply_t      r;
      int unsigned sh, wi, w;
      logic [31:0] word, data;
      r.rx_byte   = IDLE_BYTE;
      r.err_valid = 1'b0;
      r.err_code  = ERR_OK;
      if (desel) begin
         ph = PH_IDLE;
      end else if (ph != PH_IDLE) begin
         sh = 8 * addr[1:0];
         wi = (32'(addr) >> 2) % MEM_WORDS;
         case (ph)
            PH_HOLD: ;
            PH_STATUS: begin
               r.rx_byte = wel ? STATUS_WEL : 8'h00;
               ph = PH_HOLD;
            end
            PH_ID0: begin
               r.rx_byte = JEDEC_MFR;
               ph = PH_ID1;
            end
            PH_ID1: begin
               r.rx_byte = 8'((MEM_WORDS >> 18) & 255);
               ph = PH_ID2;
            end
            PH_ID2: begin
               r.rx_byte = 8'((MEM_WORDS >> 10) & 255);
               ph = PH_HOLD;
            end
            PH_ADDR_HI: begin
               addr = {b, 16'h0000};
               ph = PH_ADDR_MID;
            end
            PH_ADDR_MID: begin
               addr = {addr[23:16], b, 8'h00};
               ph = PH_ADDR_LO;
            end
            PH_ADDR_LO: begin
               addr = {addr[23:8], b};
               if (32'(addr) < MEM_BYTES) begin
                  if (opcode == OPC_SECT_ERASE) begin
                     if (wel) begin
                        r.err_valid = 1'b1;
                        w = 32'(addr) >> 2;
                        if (addr[1:0] != 2'b00) begin
                           r.err_code = ERR_MISALIGNED;
                        end else if (w + SECTOR_WORDS > MEM_WORDS) begin
                           r.err_code = ERR_RANGE;
                        end else begin
                           for (int i = 0; i < SECTOR_WORDS; i++)
                              flash_mem[w + i] = ERASED_WORD;
                        end
                     end
                     wel = 1'b0;
                     ph = PH_HOLD;
                  end else if (opcode == OPC_FAST_READ) begin
                     ph = PH_DUMMY;
                  end else if (opcode == OPC_PAGE_PROG) begin
                     ph = PH_PROG;
                  end else begin
                     ph = PH_IDLE;
                  end
               end else begin
                  ph = PH_HOLD;  // address out of range: wait for deselect
               end
            end
            PH_DUMMY: ph = PH_READ;
            PH_READ: begin
               r.rx_byte = 8'(flash_mem[wi] >> sh);
               addr = advance_addr(addr);
            end
            PH_PROG: begin
               word = flash_mem[wi];
               data = ~(32'h0000_00FF << sh) | (32'(b) << sh);
               if (~(word | data) != 32'h0) begin
                  r.err_valid = 1'b1;
                  r.err_code  = ERR_NOT_ERASED;
                  ph = PH_IDLE;
               end else begin
                  flash_mem[wi] = word & data;
                  addr = advance_addr(addr);
                  if (addr[7:0] == 8'h00 && !eoc) begin
                     r.err_valid = 1'b1;
                     r.err_code  = ERR_PAGE_OVF;
                     ph = PH_IDLE;
                  end
               end
            end
            default: ph = PH_IDLE;
         endcase
      end else begin
         opcode = b;
         case (b)
            OPC_READ_STATUS: ph = PH_STATUS;
            OPC_FAST_READ,
            OPC_PAGE_PROG,
            OPC_SECT_ERASE: ph = PH_ADDR_HI;
            OPC_WRITE_EN: begin
               ph  = PH_HOLD;
               wel = 1'b1;
            end
            OPC_WRITE_DIS: begin
               ph  = PH_HOLD;
               wel = 1'b0;
            end
            OPC_JEDEC_ID: ph = PH_ID0;
            default: ;
         endcase
      end
      if (!desel && eoc) ph = PH_IDLE;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         ph     = PH_IDLE;
         opcode = '0;
         wel    = 1'b0;
         addr   = '0;
         for (int i = 0; i < MEM_WORDS; i++) flash_mem[i] = ERASED_WORD;
         fail_count = 0;
         awaited_replies.delete();
         pending <= 0;
      end else begin
         if (req_tvalid && req_tready)
            awaited_replies.push_back(flash_transfer(req_tuser[0], req_tlast, req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_replies.size() == 0) begin
               report_mismatch("response beat with none awaited", 32'(rsp_tdata), 32'd0);
            end else begin
               want = awaited_replies.pop_front();
               if (rsp_tdata !== want.rx_byte)
                  report_mismatch("rx_byte", 32'(rsp_tdata), 32'(want.rx_byte));
               if (rsp_tuser[0] !== want.err_valid)
                  report_mismatch("error_valid", 32'(rsp_tuser[0]), 32'(want.err_valid));
               if (rsp_tuser[3:1] !== want.err_code)
                  report_mismatch("error_code", 32'(rsp_tuser[3:1]), 32'(want.err_code));
            end
         end
         pending <= awaited_replies.size();
      end
   end

endmodule

[tb/tb_top.sv]
// Testbench top for the SPI flash slave model: clock, reset, beat stimulus and the verdict.
module tb_top;
   import sfsm_pkg::*;

   localparam int MEM_WORDS    = MEM_WORDS_DEF;
   localparam int SECTOR_WORDS = SECTOR_WORDS_DEF;
   localparam int MEM_BYTES    = MEM_WORDS * 4;
   localparam int SECTOR_BYTES = SECTOR_WORDS * 4;
   localparam int FOCUS_BYTES  = 2 * SECTOR_BYTES;  // most traffic lands here

   localparam logic [7:0] NOT_AN_OPCODE = 8'hFF;

   localparam int DIRECTED_BEATS = 26;
   localparam int RANDOM_BEATS   = 400;
   localparam int HOLD_AT_BEAT   = 150;   // hold-off starts once this many beats went in
   localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
   localparam int TAIL_CYCLES    = 40;
   localparam int LIMIT_CYCLES   = 1_000_000;

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;   // [7:0] tx_byte
   logic       req_tlast;   // end_of_command
   logic [0:0] req_tuser;   // [0] deselect_before
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;   // [7:0] rx_byte
   logic [3:0] rsp_tuser;   // [0] error_valid, [3:1] error_code

   int unsigned fail_count;
   int unsigned pending;
   int unsigned beats_sent = 0;
   bit          gaps_on    = 1'b1;

   spi_flash_slave_model #(
      .MEM_WORDS   (MEM_WORDS),
      .SECTOR_WORDS(SECTOR_WORDS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   flash_reply_check #(
      .MEM_WORDS   (MEM_WORDS),
      .SECTOR_WORDS(SECTOR_WORDS)
   ) u_reply_check (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .fail_count(fail_count),
      .pending   (pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Backstop. The slowest honest run is the clearing sweep after reset, a few
   // dozen sector erases and some 450 beats with stalls.
   initial begin
      #(4 * LIMIT_CYCLES);
      $display("*** FAILED ***");
      $finish;
   end

   // Response side: random back-pressure, plus one long hold-off once enough
   // beats went in, so the block fills up and drops req_tready while beats
   // keep coming.
   initial begin
      bit hold_done;
      hold_done = 1'b0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!hold_done && beats_sent >= HOLD_AT_BEAT) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_tready <= !(gaps_on && $urandom_range(0, 99) < 9);
         end
      end
   end

   // One byte transfer. Random idle cycles go before the beat; tvalid then
   // stays high until the handshake edge.
   task automatic send_beat(input logic desel, input logic eoc, input logic [7:0] b);
      while (gaps_on && $urandom_range(0, 99) < 9) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= desel;
      req_tlast  <= eoc;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      beats_sent++;
   endtask

   // Opcode followed by n_extra filler bytes, chip select rising after the last.
   task automatic send_cmd(input logic [7:0] opc, input int n_extra);
      send_beat(1'b0, n_extra == 0, opc);
      for (int i = 1; i <= n_extra; i++) send_beat(1'b0, i == n_extra, 8'($urandom));
   endtask

   // Partly erased-friendly data: a quarter of the bytes are all ones.
   function automatic logic [7:0] pick_data();
      return ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
   endfunction

   // Opcode, 3-byte big-endian address, then n_data bytes (dummy included
   // for reads). With close low the transaction is left hanging.
   task automatic send_addressed(input logic [7:0] opc, input logic [23:0] a,
                                 input int n_data, input bit close);
      send_beat(1'b0, 1'b0, opc);
      send_beat(1'b0, 1'b0, a[23:16]);
      send_beat(1'b0, 1'b0, a[15:8]);
      send_beat(1'b0, close && n_data == 0, a[7:0]);
      for (int i = 1; i <= n_data; i++) send_beat(1'b0, close && i == n_data, pick_data());
   endtask

   function automatic logic [23:0] pick_addr();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return 24'($urandom_range(0, FOCUS_BYTES - 1));
         5, 6:          return 24'(MEM_BYTES - $urandom_range(1, 300));      // wrap zone
         7:             return 24'($urandom_range(0, MEM_BYTES - 1));
         8:             return 24'($urandom);                                // mostly beyond the store
         default:       return 24'($urandom_range(1, FOCUS_BYTES / 256) * 256
                                   - $urandom_range(1, 8));                 // just short of a page end
      endcase
   endfunction

   function automatic logic [23:0] pick_erase_addr();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return 24'($urandom_range(0, 1) * SECTOR_BYTES);
         5:             return 24'(MEM_BYTES - SECTOR_BYTES);               // last whole sector
         6:             return 24'($urandom_range(0, FOCUS_BYTES / 4 - 1) * 4);
         7:             return 24'($urandom_range(0, 1) * SECTOR_BYTES + $urandom_range(1, 3));
         8:             return 24'(MEM_BYTES - 4 * $urandom_range(1, SECTOR_WORDS - 1));
         default:       return 24'($urandom);
      endcase
   endfunction

   initial begin
      int          kind;
      int          n;
      logic [23:0] top_addr;
      top_addr = 24'(MEM_BYTES - 1);

      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      req_tuser  <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: every command, abort, unknown opcode, erase while write
      // protected, programme at the very top with wrap into page overflow,
      // then a read across the wrap point.
      send_cmd(OPC_WRITE_EN, 0);
      send_cmd(OPC_READ_STATUS, 1);
      send_cmd(OPC_WRITE_DIS, 0);
      send_cmd(OPC_JEDEC_ID, 3);
      send_beat(1'b1, 1'b1, 8'h00);
      send_cmd(NOT_AN_OPCODE, 0);
      send_addressed(OPC_SECT_ERASE, 24'h000000, 0, 1'b1);
      send_beat(1'b0, 1'b0, OPC_PAGE_PROG);
      send_beat(1'b0, 1'b0, top_addr[23:16]);
      send_beat(1'b0, 1'b0, top_addr[15:8]);
      send_beat(1'b0, 1'b0, top_addr[7:0]);
      send_beat(1'b0, 1'b0, 8'h00);
      send_addressed(OPC_FAST_READ, top_addr, 3, 1'b1);

      // Random: mostly well-formed transactions, the rest noise and
      // transactions cut short by a deselect.
      while (beats_sent < DIRECTED_BEATS + RANDOM_BEATS) begin
         gaps_on = !(beats_sent >= 250 && beats_sent < 340);
         kind = $urandom_range(0, 99);
         if (kind < 6) begin
            send_cmd(OPC_READ_STATUS, $urandom_range(1, 2));
         end else if (kind < 14) begin
            send_cmd(OPC_WRITE_EN, 0);
         end else if (kind < 18) begin
            send_cmd(OPC_WRITE_DIS, 0);
         end else if (kind < 22) begin
            send_cmd(OPC_JEDEC_ID, $urandom_range(1, 5));
         end else if (kind < 42) begin
            send_addressed(OPC_PAGE_PROG, pick_addr(), $urandom_range(1, 20),
                           $urandom_range(0, 9) != 0);
         end else if (kind < 62) begin
            send_addressed(OPC_FAST_READ, pick_addr(), $urandom_range(1, 17),
                           $urandom_range(0, 9) != 0);
         end else if (kind < 70) begin
            if ($urandom_range(0, 4) != 0) send_cmd(OPC_WRITE_EN, 0);
            send_addressed(OPC_SECT_ERASE, pick_erase_addr(), 0, 1'b1);
         end else if (kind < 78) begin
            send_cmd(8'($urandom), $urandom_range(0, 2));
         end else if (kind < 90) begin
            // addressed command broken off by a deselect
            case ($urandom_range(0, 2))
               0:       send_beat(1'b0, 1'b0, OPC_PAGE_PROG);
               1:       send_beat(1'b0, 1'b0, OPC_FAST_READ);
               default: send_beat(1'b0, 1'b0, OPC_SECT_ERASE);
            endcase
            n = $urandom_range(0, 5);
            repeat (n) send_beat(1'b0, 1'b0, 8'($urandom));
            send_beat(1'b1, 1'($urandom_range(0, 1)), 8'($urandom));
         end else begin
            send_beat($urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)), 8'($urandom));
         end
      end
      req_tvalid <= 1'b0;
      gaps_on = 1'b1;

      // Drain: an erase beat may still be sweeping its sector.
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fail_count == 0 && pending == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
